// File: rtl/core/assert_macros.svh
// Assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ges_pkg.sv
package ges_pkg;

    localparam int MAX_N      = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = $clog2(MAX_N);
    localparam int CNT_W      = $clog2(MAX_N + 1);
    localparam int MAT_DEPTH  = MAX_N * (MAX_N + 1);
    localparam int MAT_AW     = $clog2(MAT_DEPTH);
    localparam int DIV_W      = DATA_W + FRAC_BITS;
    localparam int DIV_CW     = $clog2(DIV_W + 1);
    localparam int PROD_W     = 2 * DATA_W;

    function automatic logic [DATA_W-1:0] fx_mag(input logic [DATA_W-1:0] a);
        fx_mag = a[DATA_W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [DATA_W-1:0] fx_sat_mag(input logic [PROD_W-1:0] m,
                                                     input logic neg);
        logic [PROD_W-1:0] lim;
        lim = PROD_W'(1) << (DATA_W - 1);
        if (neg) begin
            fx_sat_mag = (m >= lim) ? {1'b1, {(DATA_W-1){1'b0}}} : (~m[DATA_W-1:0] + 1'b1);
        end else begin
            fx_sat_mag = (m >= lim) ? {1'b0, {(DATA_W-1){1'b1}}} : m[DATA_W-1:0];
        end
    endfunction

    function automatic logic [DATA_W-1:0] fx_sat_sub(input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1]) begin
            fx_sat_sub = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            fx_sat_sub = d[DATA_W-1:0];
        end
    endfunction

endpackage

// File: rtl/core/gaussian_elimination_solver_unit.sv
// Fixed-point linear system solver, Gaussian elimination without pivoting.
// Configuration: write the unknown count N (1..16, 0 acts as 1) on
// i_cfg_valid/i_cfg_data while idle; every write restarts matrix loading.
// Input stream: N*(N+1) signed Q16.16 entries, row-major, right-hand side
// last in each row, one transaction per cycle while loading.
// After the final entry the input stalls while the block eliminates and
// back-substitutes on one shared multiply path and a 48-step serial
// divider, with operands read from the matrix RAM and the solution RAM.
// Forward work goes pivot by pivot: a zero pivot skips its column, else
// each row below gets a coefficient from the divider and its remaining
// entries are updated. Back work accumulates the terms of each unknown and
// divides by its pivot, unless its solution is invalid.
// Output stream: N transactions x0..x(N-1), each presented only after the
// previous one is accepted; tuser marks a valid solution, tlast the final
// one. A stalled receiver holds the output register and the block; loading resumes after tlast.
// Reset returns to loading with N=4 and clears the invalid flags.
module gaussian_elimination_solver_unit import ges_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,       // system_size
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,     // [31:0] entry_value
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [39:0]      m_axis_tdata,     // [3:0] solution_index, [35:4] solution_value
    output logic             m_axis_tuser,     // [0] solution_valid
    output logic             m_axis_tlast
);

    `include "assert_macros.svh"

    typedef enum logic [21:0] {
        S_LOAD  = 22'h000001,
        S_FCHK  = 22'h000002,
        S_FPRD  = 22'h000004,
        S_FPCAP = 22'h000008,
        S_FCRD  = 22'h000010,
        S_FCCAP = 22'h000020,
        S_FCDIV = 22'h000040,
        S_FARD  = 22'h000080,
        S_FBRD  = 22'h000100,
        S_MUL   = 22'h000200,
        S_SAT   = 22'h000400,
        S_SUB   = 22'h000800,
        S_BSRD  = 22'h001000,
        S_BSCAP = 22'h002000,
        S_BTRD  = 22'h004000,
        S_BPRD  = 22'h008000,
        S_BPCAP = 22'h010000,
        S_BDIV  = 22'h020000,
        S_BNEXT = 22'h040000,
        S_ORD   = 22'h080000,
        S_OLD   = 22'h100000,
        S_OWAIT = 22'h200000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_n;
    logic [MAT_AW-1:0] r_load;
    logic [CNT_W-1:0]  r_i, r_k, r_j;
    logic              r_back;
    logic              r_taint;
    logic [MAX_N-1:0]  r_inv;
    logic [DATA_W-1:0] r_piv, r_coeff, r_opb, r_min, r_term, r_s;
    logic [PROD_W-1:0] r_prod;
    logic              r_pneg;
    logic              r_ovalid, r_ouser, r_olast;
    logic [IDX_W-1:0]  r_oidx;
    logic [DATA_W-1:0] r_oval;

    logic [CNT_W-1:0]  n_cfg;
    logic [CNT_W:0]    n_w;
    logic [MAT_AW-1:0] n_total;
    logic [CNT_W-1:0]  n_row, n_col;
    logic [MAT_AW-1:0] n_addr;
    logic              n_in_acc;
    logic              n_m_we;
    logic [MAT_AW-1:0] n_m_waddr;
    logic [DATA_W-1:0] n_m_wdata;
    logic [DATA_W-1:0] n_mrd, n_xrd;
    logic              n_x_we;
    logic [DATA_W-1:0] n_x_wdata;
    logic [IDX_W-1:0]  n_x_raddr;
    logic [DATA_W-1:0] n_opa, n_opb, n_sub;
    logic              n_div_start;
    logic [DATA_W-1:0] n_div_a, n_div_b, n_div_q;
    logic              n_div_busy, n_div_done;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_cfg = CNT_W'(1);
        end else if (i_cfg_data > CFG_W'(MAX_N)) begin
            n_cfg = CNT_W'(MAX_N);
        end else begin
            n_cfg = CNT_W'(i_cfg_data);
        end
    end

    assign n_w     = {1'b0, r_n} + 1'b1;
    assign n_total = MAT_AW'(r_n) * MAT_AW'(n_w);

    always_comb begin
        n_row = r_i;
        n_col = r_i;
        case (r_state)
            S_FCRD:         begin n_row = r_k; n_col = r_i; end
            S_FARD, S_BTRD: begin n_row = r_i; n_col = r_j; end
            S_FBRD, S_SUB:  begin n_row = r_k; n_col = r_j; end
            S_BSRD:         begin n_row = r_i; n_col = r_n; end
            default:        begin n_row = r_i; n_col = r_i; end
        endcase
    end

    assign n_addr   = MAT_AW'(n_row) * MAT_AW'(n_w) + MAT_AW'(n_col);
    assign n_in_acc = s_axis_tvalid && s_axis_tready;

    assign n_m_we    = n_in_acc || (r_state == S_SUB && !r_back);
    assign n_m_waddr = (r_state == S_LOAD) ? r_load : n_addr;
    assign n_sub     = fx_sat_sub(r_min, r_term);
    assign n_m_wdata = (r_state == S_LOAD) ? s_axis_tdata : n_sub;

    ges_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_mat (
        .i_clk   (i_clk),
        .i_we    (n_m_we),
        .i_waddr (n_m_waddr),
        .i_wdata (n_m_wdata),
        .i_raddr (n_addr),
        .o_rdata (n_mrd)
    );

    assign n_x_we    = (r_state == S_BPCAP && (n_mrd == '0 || r_taint))
                    || (r_state == S_BDIV && n_div_done);
    assign n_x_wdata = (r_state == S_BDIV) ? n_div_q : '0;
    assign n_x_raddr = (r_state == S_BTRD) ? r_j[IDX_W-1:0] : r_k[IDX_W-1:0];

    ges_ram #(.WIDTH(DATA_W), .DEPTH(MAX_N)) u_sol (
        .i_clk   (i_clk),
        .i_we    (n_x_we),
        .i_waddr (r_i[IDX_W-1:0]),
        .i_wdata (n_x_wdata),
        .i_raddr (n_x_raddr),
        .o_rdata (n_xrd)
    );

    assign n_div_start = (r_state == S_FCCAP)
                      || (r_state == S_BPCAP && n_mrd != '0 && !r_taint);
    assign n_div_a     = (r_state == S_FCCAP) ? n_mrd : r_s;
    assign n_div_b     = (r_state == S_FCCAP) ? r_piv : n_mrd;

    ges_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_a     (n_div_a),
        .i_b     (n_div_b),
        .o_busy  (n_div_busy),
        .o_done  (n_div_done),
        .o_q     (n_div_q)
    );

    assign n_opa = r_back ? n_mrd : r_coeff;
    assign n_opb = r_back ? n_xrd : r_opb;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (n_in_acc && r_load + 1'b1 == n_total) n_state = S_FCHK;
            S_FCHK:  n_state = (r_i + 1'b1 < r_n) ? S_FPRD : S_BSRD;
            S_FPRD:  n_state = S_FPCAP;
            S_FPCAP: n_state = (n_mrd == '0) ? S_FCHK : S_FCRD;
            S_FCRD:  n_state = S_FCCAP;
            S_FCCAP: n_state = S_FCDIV;
            S_FCDIV: if (n_div_done) n_state = S_FARD;
            S_FARD:  n_state = S_FBRD;
            S_FBRD:  n_state = S_MUL;
            S_MUL:   n_state = S_SAT;
            S_SAT:   n_state = S_SUB;
            S_SUB: begin
                if (r_back) begin
                    n_state = (r_j + 1'b1 < r_n) ? S_BTRD : S_BPRD;
                end else if (r_j < r_n) begin
                    n_state = S_FARD;
                end else if (r_k + 1'b1 < r_n) begin
                    n_state = S_FCRD;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_BSRD:  n_state = S_BSCAP;
            S_BSCAP: n_state = (r_i + 1'b1 < r_n) ? S_BTRD : S_BPRD;
            S_BTRD:  n_state = S_MUL;
            S_BPRD:  n_state = S_BPCAP;
            S_BPCAP: n_state = (n_mrd == '0 || r_taint) ? S_BNEXT : S_BDIV;
            S_BDIV:  if (n_div_done) n_state = S_BNEXT;
            S_BNEXT: n_state = (r_i == '0) ? S_ORD : S_BSRD;
            S_ORD:   n_state = S_OLD;
            S_OLD:   n_state = S_OWAIT;
            S_OWAIT: begin
                if (m_axis_tready) begin
                    n_state = r_olast ? S_LOAD : S_ORD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_n      <= CNT_W'(4);
            r_load   <= '0;
            r_inv    <= '0;
            r_ovalid <= 1'b0;
            r_back   <= 1'b0;
            r_taint  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_n    <= n_cfg;
                r_load <= '0;
            end else if (n_in_acc) begin
                r_load <= (r_load + 1'b1 == n_total) ? '0 : r_load + 1'b1;
            end
            case (r_state)
                S_LOAD: begin
                    r_i    <= '0;
                    r_back <= 1'b0;
                end
                S_FCHK: begin
                    if (r_i + 1'b1 >= r_n) begin
                        r_i     <= r_n - 1'b1;
                        r_back  <= 1'b1;
                        r_taint <= 1'b0;
                    end
                end
                S_FPCAP: begin
                    r_piv <= n_mrd;
                    r_k   <= r_i + 1'b1;
                    if (n_mrd == '0) r_i <= r_i + 1'b1;
                end
                S_FCDIV: begin
                    r_coeff <= n_div_q;
                    r_j     <= r_i + 1'b1;
                end
                S_FBRD: r_opb <= n_mrd;
                S_MUL: begin
                    r_prod <= PROD_W'(fx_mag(n_opa)) * PROD_W'(fx_mag(n_opb));
                    r_pneg <= n_opa[DATA_W-1] ^ n_opb[DATA_W-1];
                    r_min  <= r_back ? r_s : n_mrd;
                end
                S_SAT: r_term <= fx_sat_mag(r_prod >> FRAC_BITS, r_pneg);
                S_SUB: begin
                    r_j <= r_j + 1'b1;
                    if (r_back) begin
                        r_s <= n_sub;
                    end else if (r_j >= r_n) begin
                        if (r_k + 1'b1 < r_n) begin
                            r_k <= r_k + 1'b1;
                            r_j <= r_i + 1'b1;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_FCCAP: ;
                S_BSCAP: begin
                    r_s <= n_mrd;
                    r_j <= r_i + 1'b1;
                end
                S_BPCAP: begin
                    if (n_mrd == '0 || r_taint) begin
                        r_taint <= 1'b1;
                        r_inv[r_i[IDX_W-1:0]] <= 1'b1;
                    end
                end
                S_BDIV: if (n_div_done) r_inv[r_i[IDX_W-1:0]] <= 1'b0;
                S_BNEXT: begin
                    r_k <= '0;
                    if (r_i != '0) r_i <= r_i - 1'b1;
                end
                S_OLD: begin
                    r_ovalid <= 1'b1;
                    r_oidx   <= r_k[IDX_W-1:0];
                    r_oval   <= n_xrd;
                    r_ouser  <= !r_inv[r_k[IDX_W-1:0]];
                    r_olast  <= (r_k + 1'b1 == r_n);
                end
                S_OWAIT: begin
                    if (m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        r_k      <= r_k + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0, r_oval, r_oidx};
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    `ASSERT_IMPLIES(a_out_in_wait, m_axis_tvalid, r_state == S_OWAIT, "output valid outside wait")
    `ASSERT_ALWAYS(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "load while results pending")
    `ASSERT_IMPLIES(a_div_owner, n_div_busy, r_state == S_FCDIV || r_state == S_BDIV, "stray divide")
    `ASSERT_ALWAYS(a_load_bound, r_load < n_total, "load count past matrix end")

endmodule

// File: rtl/core/ges_ram.sv
module ges_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/ges_div.sv
module ges_div import ges_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_busy,
    output logic              o_done,
    output logic [DATA_W-1:0] o_q
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DIV_W-1:0]  r_dvd;
    logic [DATA_W-1:0] r_bdiv;
    logic              r_neg;
    logic [DATA_W:0]   n_sh;
    logic              n_bit;

    always_comb begin
        n_sh  = {r_rem[DATA_W-1:0], r_dvd[DIV_W-1]};
        n_bit = (n_sh >= {1'b0, r_bdiv});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= {fx_mag(i_a), {FRAC_BITS{1'b0}}};
                r_bdiv <= fx_mag(i_b);
                r_neg  <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            end else if (r_busy) begin
                r_rem <= n_bit ? (n_sh - {1'b0, r_bdiv}) : n_sh;
                r_dvd <= {r_dvd[DIV_W-2:0], n_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = fx_sat_mag(PROD_W'(r_dvd), r_neg);

endmodule

// File: verif/gaussian_elimination_solver_unit_test.sv
module gaussian_elimination_solver_unit_test;
    import ges_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [3:0]        idx;
        logic [DATA_W-1:0] value;
        logic              ok;
        logic              last;
    } t_solution;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [39:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;

    logic [DATA_W-1:0] entry_q[$];
    t_solution         solution_q[$];
    logic [DATA_W-1:0] matrix[MAT_DEPTH];
    bit                solution_q_tmp[MAX_N];
    int                unknowns;
    int                loaded;
    int                gap_left;
    int                stall_left;
    int                hold_left;
    int                errors;
    int                cycles;
    bit                calm;

    gaussian_elimination_solver_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned mag_of(logic [DATA_W-1:0] a);
        return a[DATA_W-1] ? longint'(64'd0 - {{32{a[31]}}, a}) : longint'(a);
    endfunction

    function automatic logic [DATA_W-1:0] saturate(longint unsigned m, bit neg);
        if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(m);
    endfunction

    function automatic logic [DATA_W-1:0] q_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        return saturate((mag_of(a) * mag_of(b)) >> FRAC_BITS, a[31] != b[31]);
    endfunction

    function automatic logic [DATA_W-1:0] q_div(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        return saturate((mag_of(a) << FRAC_BITS) / mag_of(b), a[31] != b[31]);
    endfunction

    function automatic logic [DATA_W-1:0] q_sub(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (d < -64'sh8000_0000) return 32'h8000_0000;
        return 32'(d);
    endfunction

    task automatic solve_system();
        int w;
        bit tainted;
        logic [DATA_W-1:0] piv, coeff, acc;
        logic [DATA_W-1:0] x[MAX_N];
        t_solution s;
        w = unknowns + 1;
        tainted = 0;
        for (int i = 0; i + 1 < unknowns; i++) begin
            piv = matrix[i*w+i];
            if (piv == 0) continue;
            for (int k = i + 1; k < unknowns; k++) begin
                coeff = q_div(matrix[k*w+i], piv);
                for (int j = i + 1; j <= unknowns; j++)
                    matrix[k*w+j] = q_sub(matrix[k*w+j], q_mul(coeff, matrix[i*w+j]));
                matrix[k*w+i] = 0;
            end
        end
        for (int i = unknowns - 1; i >= 0; i--) begin
            acc = matrix[i*w+unknowns];
            for (int j = i + 1; j < unknowns; j++)
                acc = q_sub(acc, q_mul(matrix[i*w+j], x[j]));
            piv = matrix[i*w+i];
            if (piv == 0) tainted = 1;
            x[i] = tainted ? '0 : q_div(acc, piv);
            solution_q_tmp[i] = !tainted;
        end
        for (int i = 0; i < unknowns; i++) begin
            s.idx   = 4'(i);
            s.value = x[i];
            s.ok    = solution_q_tmp[i];
            s.last  = (i == unknowns - 1);
            solution_q.push_back(s);
        end
    endtask

    task automatic load_entry(logic [DATA_W-1:0] v);
        matrix[loaded] = v;
        loaded++;
        if (loaded == unknowns * (unknowns + 1)) begin
            loaded = 0;
            solve_system();
        end
    endtask

    function automatic int draw_idle();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) load_entry(s_axis_tdata);
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (entry_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= entry_q.pop_front();
                    gap_left      <= draw_idle();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        int st;
        t_solution want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            st = stall_left;
            if (m_axis_tvalid && m_axis_tready) begin
                if (solution_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected solution %h", m_axis_tdata);
                end else begin
                    want = solution_q.pop_front();
                    if (m_axis_tdata[3:0] !== want.idx || m_axis_tdata[35:4] !== want.value ||
                        m_axis_tdata[39:36] !== 4'd0 || m_axis_tuser !== want.ok ||
                        m_axis_tlast !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp idx %0d val %h ok %b last %b, got %h %b %b",
                                     want.idx, want.value, want.ok, want.last,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
                st = draw_idle();
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (st > 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= st - 1;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left    <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (entry_q.size() > 0 || s_axis_tvalid || solution_q.size() > 0 || hold_left > 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] v);
        int n;
        wait_drained();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        n = (v == 0) ? 1 : (v > MAX_N) ? MAX_N : v;
        unknowns = n;
        loaded   = 0;
    endtask

    function automatic logic [DATA_W-1:0] rand_entry(int kind, bit diag);
        logic [DATA_W-1:0] v;
        case (kind)
            0: begin
                v = diag ? 32'($urandom_range(2, 8) << FRAC_BITS) + $urandom_range(0, 65535)
                         : 32'($urandom_range(0, 65536));
                if ($urandom_range(0, 1)) v = -v;
            end
            1: v = $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 32'h0001_0000;
                    2: v = -32'($urandom_range(0, 3 << FRAC_BITS));
                    default: v = $urandom_range(0, 5 << FRAC_BITS);
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic queue_system(int n, int kind);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
                entry_q.push_back(rand_entry(kind, r == c));
    endtask

    initial begin
        int added;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        errors      = 0;
        cycles      = 0;
        hold_left   = 0;
        calm        = 0;
        unknowns    = 4;
        loaded      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // size after reset, zero first pivot: skip column and invalidate x0
        for (int r = 0; r < 4; r++)
            for (int c = 0; c <= 4; c++)
                entry_q.push_back((r == 0 && c == 0) ? 32'h0 :
                                  (r == c) ? 32'h0003_0000 : rand_entry(0, 0));
        // size 0 acts as 1: saturating quotient, then zero pivot
        write_size(5'd0);
        entry_q.push_back(32'h0000_0001);
        entry_q.push_back(32'h7FFF_FFFF);
        entry_q.push_back(32'h0000_0000);
        entry_q.push_back(32'h8000_0000);

        // size change while loading
        write_size(5'd16);
        for (int i = 0; i < 7; i++) entry_q.push_back($urandom);

        // long receiver hold while the sender keeps going
        write_size(5'd2);
        calm = 1;
        @(negedge i_clk);
        hold_left = 600;
        for (int i = 0; i < 2; i++) queue_system(2, i % 3);
        wait_drained();
        calm = 0;

        write_size(5'd31);
        queue_system(16, 1);

        added = 0;
        while (added < 6) begin
            int n;
            n = $urandom_range(1, 3);
            write_size(5'(n));
            calm = ($urandom_range(0, 3) == 0);
            for (int s = $urandom_range(1, 2); s > 0; s--) begin
                queue_system(n, $urandom_range(0, 2));
                added += n * (n + 1);
            end
        end

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (errors == 0 && solution_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
